FILE: rtl/tksk_pkg.sv
// Package for the top-K smallest keeper: field widths, command and register codes,
// and the structs passed between the top level and the cells.
// No dependencies.
`default_nettype none
package tksk_pkg;

	localparam int unsigned MAX_KEEP_DEF = 64;
	localparam int unsigned VAL_W        = 32;
	localparam int unsigned ATT_W        = 32;
	localparam int unsigned KEEP_W       = 7;
	localparam int unsigned RANK_W       = 6;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned S_TDATA_W    = 40;
	localparam int unsigned M_TDATA_W    = 176;

	localparam logic [VAL_W-1:0]  THRESH_RST = '0;
	localparam logic [KEEP_W-1:0] KEEP_RST   = 7'd64;
	localparam logic [ATT_W-1:0]  LIMIT_RST  = '1;
	localparam logic [ATT_W-1:0]  ATT_MAX    = '1;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_KEEP      = 2'd1,
		CFG_LIMIT     = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic                    wr_en;
		logic signed [VAL_W-1:0] cand;
		logic [ATT_W-1:0]        stamp;
	} cell_bcast_t;

	// What a cell shows to its right neighbor and to the top level.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [ATT_W-1:0]        attempt;
		logic                    ge;
		logic                    raw_ge;
		logic signed [VAL_W-1:0] nxt_value;
		logic [ATT_W-1:0]        nxt_attempt;
	} cell_out_t;

endpackage
`default_nettype wire

FILE: rtl/top_k_smallest_keeper.sv
// Top level of the top-K smallest keeper: stream ports, configuration registers,
// insert control, the row of tksk_cell instances and the output register.
// Depends on tksk_pkg and tksk_cell.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  s_*      | s_tvalid s_tready s_tdata s_tuser        | in  (one command per beat)
//  m_*      | m_tvalid m_tready m_tdata                | out (one result per beat)
//  cfg_*    | cfg_valid cfg_ready cfg_index cfg_data   | in  (register writes)
//
//  Every beat, insert or read, finishes in the cycle it is accepted: all cells compare
//  the candidate at once and shift in one step, so one beat per cycle is sustained while
//  m_tready stays high, and the result shows on m_* in the cycle after acceptance.
//  arst_n clears the count, attempt counter, sticky flag and output valid, and resets the config registers to defaults.
//  A stalled m_* holds its beat; s_tready drops only while that beat is still waiting.
`default_nettype none
module top_k_smallest_keeper #(
	parameter int unsigned MAX_KEEP = tksk_pkg::MAX_KEEP_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// cand_value [31:0], rank [37:32], zero pad [39:38]
	input  wire  [tksk_pkg::S_TDATA_W-1:0]     s_tdata,
	// cmd [0]
	input  wire                                s_tuser,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// kept [0], attempt_number [32:1], done_res [33], best_value [65:34],
	// best_attempt [97:66], stored_count [104:98], read_value [136:105],
	// read_attempt [168:137], read_valid [169], zero pad [175:170]
	output logic [tksk_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [tksk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [31:0]                        cfg_data
);
	import tksk_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_KEEP + 1);
	localparam int unsigned CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

	// configuration
	logic signed [VAL_W-1:0] thresh_q;
	logic [KEEP_W-1:0]       keep_q;
	logic [ATT_W-1:0]        limit_q;

	// block state
	logic [CNT_W-1:0]        count_q;
	logic [ATT_W-1:0]        attempt_q;
	logic                    hit_q;

	// output register
	logic                    m_valid_q;
	logic [M_TDATA_W-1:0]    m_data_q;

	// decoded input beat
	logic                    accept;
	cmd_t                    cmd;
	logic signed [VAL_W-1:0] cand;
	logic [RANK_W-1:0]       rank;
	logic                    is_insert;

	logic [CMP_W-1:0]        keep_ext;
	logic [CMP_W-1:0]        keep_eff;
	logic [CMP_W-1:0]        count_ext;
	logic [CMP_W-1:0]        held;
	logic                    not_full;
	logic [CMP_W-1:0]        lim;
	logic                    full_ge;
	logic                    kept;
	logic [CMP_W-1:0]        count_nxt_ext;
	logic [CNT_W-1:0]        count_nxt;
	logic [ATT_W-1:0]        attempt_nxt;
	logic                    hit_nxt;
	logic                    done;
	logic                    rd_valid;
	logic signed [VAL_W-1:0] rd_value;
	logic [ATT_W-1:0]        rd_attempt;
	logic signed [VAL_W-1:0] best_value;
	logic [ATT_W-1:0]        best_attempt;
	logic [M_TDATA_W-1:0]    result;

	cell_bcast_t             bcast;
	cell_out_t               cells [MAX_KEEP];

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	assign cmd       = cmd_t'(s_tuser);
	assign cand      = s_tdata[VAL_W-1:0];
	assign rank      = s_tdata[VAL_W +: RANK_W];
	assign is_insert = (cmd == CMD_INSERT);

	// Keep count of zero acts as one; anything past the row length is clamped to it.
	assign keep_ext = CMP_W'(keep_q);
	always_comb begin
		priority if (keep_ext == '0)
			keep_eff = CMP_W'(1);
		else if (keep_ext > CMP_W'(MAX_KEEP))
			keep_eff = CMP_W'(MAX_KEEP);
		else
			keep_eff = keep_ext;
	end

	// A lowered keep count truncates the store on the next insert.
	assign count_ext = CMP_W'(count_q);
	assign held      = (count_ext > keep_eff) ? keep_eff : count_ext;
	assign not_full  = (held < keep_eff);
	assign lim       = not_full ? held : (keep_eff - CMP_W'(1));

	// Full store: keep the candidate unless the last entry is strictly smaller.
	always_comb begin
		full_ge = 1'b0;
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (CMP_W'(i) == lim)
				full_ge = cells[i].raw_ge;
		end
	end

	assign kept          = is_insert && (not_full || full_ge);
	assign count_nxt_ext = not_full ? (held + CMP_W'(1)) : keep_eff;
	assign count_nxt     = is_insert ? CNT_W'(count_nxt_ext) : count_q;

	assign attempt_nxt = (is_insert && (attempt_q != ATT_MAX)) ? (attempt_q + ATT_W'(1))
		: attempt_q;
	assign hit_nxt     = hit_q || (is_insert && (cand < thresh_q));
	assign done        = hit_nxt || (attempt_nxt > limit_q);

	assign bcast.wr_en = accept && kept;
	assign bcast.cand  = cand;
	assign bcast.stamp = attempt_nxt;

	// Row of cells; each one shifts in from its left neighbor.
	for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
		if (g == 0) begin : g_head
			tksk_cell #(
				.LIM_W (CMP_W),
				.INDEX (g)
			) u_cell (
				.clk          (clk),
				.bcast        (bcast),
				.lim          (lim),
				.prev         ('0),
				.prev_present (1'b0),
				.cout         (cells[0])
			);
		end else begin : g_body
			tksk_cell #(
				.LIM_W (CMP_W),
				.INDEX (g)
			) u_cell (
				.clk          (clk),
				.bcast        (bcast),
				.lim          (lim),
				.prev         (cells[g-1]),
				.prev_present (1'b1),
				.cout         (cells[g])
			);
		end
	end

	// Read port: rank-selected entry, only on a read within the stored count.
	assign rd_valid = !is_insert && (CMP_W'(rank) < count_ext);
	always_comb begin
		rd_value   = '0;
		rd_attempt = '0;
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (rd_valid && (CMP_W'(rank) == CMP_W'(i))) begin
				rd_value   = cells[i].value;
				rd_attempt = cells[i].attempt;
			end
		end
	end

	// Best entry after this beat; zero while the store is empty.
	assign best_value   = (count_nxt != '0) ? cells[0].nxt_value : '0;
	assign best_attempt = (count_nxt != '0) ? cells[0].nxt_attempt : '0;

	always_comb begin
		logic [CMP_W-1:0] cnt_out;
		cnt_out = CMP_W'(count_nxt);
		result  = '0;
		result[0]       = kept;
		result[32:1]    = attempt_nxt;
		result[33]      = done;
		result[65:34]   = best_value;
		result[97:66]   = best_attempt;
		result[104:98]  = cnt_out[KEEP_W-1:0];
		result[136:105] = rd_value;
		result[168:137] = rd_attempt;
		result[169]     = rd_valid;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			keep_q   <= KEEP_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: thresh_q <= cfg_data;
				CFG_KEEP:      keep_q   <= cfg_data[KEEP_W-1:0];
				CFG_LIMIT:     limit_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Advance the block state on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			attempt_q <= '0;
			hit_q     <= 1'b0;
		end else if (accept) begin
			count_q   <= count_nxt;
			attempt_q <= attempt_nxt;
			hit_q     <= hit_nxt;
		end
	end

	// Output register: load on accept, drop valid once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

FILE: rtl/tksk_cell.sv
// One cell of the sorted insertion row: holds one kept value and its attempt stamp.
// Depends on tksk_pkg.
`default_nettype none
module tksk_cell #(
	parameter int unsigned LIM_W = 7,
	parameter int unsigned INDEX = 0
) (
	input  wire                       clk,
	input  tksk_pkg::cell_bcast_t     bcast,
	input  wire  [LIM_W-1:0]          lim,
	input  tksk_pkg::cell_out_t       prev,
	input  wire                       prev_present,
	output tksk_pkg::cell_out_t       cout
);
	import tksk_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic [ATT_W-1:0]        attempt_q;
	logic                    beyond;
	logic                    raw_ge;
	logic                    ge;
	logic                    take_prev;
	logic signed [VAL_W-1:0] nxt_value;
	logic [ATT_W-1:0]        nxt_attempt;

	// Cells at or past the limit count as "not smaller" so the candidate stops there.
	assign beyond    = (LIM_W'(INDEX) >= lim);
	assign raw_ge    = !(value_q < bcast.cand);
	assign ge        = beyond || raw_ge;
	assign take_prev = prev_present && prev.ge;

	always_comb begin
		nxt_value   = value_q;
		nxt_attempt = attempt_q;
		if (bcast.wr_en) begin
			if (take_prev) begin
				nxt_value   = prev.value;
				nxt_attempt = prev.attempt;
			end else if (ge) begin
				nxt_value   = bcast.cand;
				nxt_attempt = bcast.stamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q   <= nxt_value;
		attempt_q <= nxt_attempt;
	end

	assign cout.value       = value_q;
	assign cout.attempt     = attempt_q;
	assign cout.ge          = ge;
	assign cout.raw_ge      = raw_ge;
	assign cout.nxt_value   = nxt_value;
	assign cout.nxt_attempt = nxt_attempt;

endmodule
`default_nettype wire
